FILE: sv/ramped_frequency_phasor_source_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the phasor source
// Concurrent assertion wrappers clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RAMPED_FREQUENCY_PHASOR_SOURCE_MACROS_SVH
`define RAMPED_FREQUENCY_PHASOR_SOURCE_MACROS_SVH

// plain property check
`define RFPS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// result word field must hold while the result side stalls
`define RFPS_ASSERT_STALL(label, sig, msg) \
   `RFPS_ASSERT(label, rsp_valid && !rsp_ready |=> rsp_valid && $stable(sig), msg)

`endif

FILE: sv/rfps_pkg.sv
// ----------------------------------------------------------------------------
// rfps_pkg
// Shared types, constants and helpers of the ramped frequency phasor source.
// ----------------------------------------------------------------------------
package rfps_pkg;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_AMPLITUDE    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PHASE_OFFSET = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ANGULAR_RATE = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SWITCH_TIME  = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RAMP_TIME    = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RAMP_RATE    = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CONDUCTANCE  = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_NODE_ENABLES = 4'd7;

   typedef enum logic [1:0] {
      REGION_BEFORE = 2'd0,
      REGION_RAMP   = 2'd1,
      REGION_AFTER  = 2'd2
   } region_type;

   // CORDIC datapath widths: x/y Q1.30 with headroom, z in 2^-32 turns
   localparam int CORDIC_XW = 33;
   localparam int CORDIC_ZW = 34;

   localparam logic signed [CORDIC_XW-1:0] INV_GAIN = 33'sd652032874;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

   // atan(2^-i) in 2^-32 turns
   localparam logic [29:0] ATAN_TURNS [32] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
      30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
      30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
      30'd166886,    30'd83443,     30'd41722,     30'd20861,
      30'd10430,     30'd5215,      30'd2608,      30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81,
      30'd41,        30'd20,        30'd10,        30'd5,
      30'd3,         30'd1,         30'd1,         30'd0
   };

   typedef struct packed {
      logic signed [31:0] volt_re;
      logic signed [31:0] volt_im;
      logic signed [31:0] inj1_re;
      logic signed [31:0] inj1_im;
      logic               inj1_valid;
      logic signed [31:0] inj2_re;
      logic signed [31:0] inj2_im;
      logic               inj2_valid;
      region_type         region;
   } rsp_word_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] value);
      logic signed [31:0] result;
      if (value[65:31] == '0 || value[65:31] == '1) begin
         result = value[31:0];
      end else if (value[65]) begin
         result = 32'sh8000_0000;
      end else begin
         result = 32'sh7fff_ffff;
      end
      return result;
   endfunction

   function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] value);
      logic signed [31:0] result;
      if (value == 32'sh8000_0000) begin
         result = 32'sh7fff_ffff;
      end else begin
         result = -value;
      end
      return result;
   endfunction

endpackage

FILE: sv/rfps_cordic_cell.sv
// ----------------------------------------------------------------------------
// rfps_cordic_cell
// One CORDIC rotation step with its register; passes a side word along.
// ----------------------------------------------------------------------------
module rfps_cordic_cell #(
   parameter int STAGE  = 0,
   parameter int SIDE_W = 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  in_valid,
   input  logic signed [rfps_pkg::CORDIC_XW-1:0] in_x,
   input  logic signed [rfps_pkg::CORDIC_XW-1:0] in_y,
   input  logic signed [rfps_pkg::CORDIC_ZW-1:0] in_z,
   input  logic        [SIDE_W-1:0]              in_side,
   output logic                                  out_valid,
   output logic signed [rfps_pkg::CORDIC_XW-1:0] out_x,
   output logic signed [rfps_pkg::CORDIC_XW-1:0] out_y,
   output logic signed [rfps_pkg::CORDIC_ZW-1:0] out_z,
   output logic        [SIDE_W-1:0]              out_side
);
   import rfps_pkg::*;

   localparam logic signed [CORDIC_ZW-1:0] ATAN_STEP = CORDIC_ZW'(ATAN_TURNS[STAGE]);

   logic signed [CORDIC_XW-1:0] dx, dy;
   logic signed [CORDIC_XW-1:0] x_in, y_in, x_ff, y_ff;
   logic signed [CORDIC_ZW-1:0] z_in, z_ff;
   logic        [SIDE_W-1:0]    side_ff;
   logic                        valid_ff;

   always_comb begin
      dx = in_y >>> STAGE;
      dy = in_x >>> STAGE;
      if (!in_z[CORDIC_ZW-1]) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ATAN_STEP;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

FILE: sv/rfps_cordic.sv
// ----------------------------------------------------------------------------
// rfps_cordic
// Row of CORDIC cells giving cosine and sine of a 32-bit turn fraction.
// ----------------------------------------------------------------------------
module rfps_cordic #(
   parameter int STAGES = 18,
   parameter int SIDE_W = 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  in_valid,
   input  logic        [31:0]                    in_phase,
   input  logic        [SIDE_W-1:0]              in_side,
   output logic                                  out_valid,
   output logic signed [rfps_pkg::CORDIC_XW-1:0] out_cos,
   output logic signed [rfps_pkg::CORDIC_XW-1:0] out_sin,
   output logic        [SIDE_W-1:0]              out_side
);
   import rfps_pkg::*;

   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;

   logic                        valid_w [STAGES+1];
   logic signed [CORDIC_XW-1:0] x_w     [STAGES+1];
   logic signed [CORDIC_XW-1:0] y_w     [STAGES+1];
   logic signed [CORDIC_ZW-1:0] z_w     [STAGES+1];
   logic        [SIDE_W+1:0]    side_w  [STAGES+1];
   logic        [1:0]           quad;
   logic signed [CORDIC_XW-1:0] x_end, y_end;

   assign valid_w[0] = in_valid;
   assign x_w[0]     = INV_GAIN;
   assign y_w[0]     = '0;
   assign z_w[0]     = CORDIC_ZW'(in_phase[29:0]);
   assign side_w[0]  = {in_phase[31:30], in_side};

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      rfps_cordic_cell #(
         .STAGE  (i),
         .SIDE_W (SIDE_W + 2)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid_w[i]),
         .in_x      (x_w[i]),
         .in_y      (y_w[i]),
         .in_z      (z_w[i]),
         .in_side   (side_w[i]),
         .out_valid (valid_w[i+1]),
         .out_x     (x_w[i+1]),
         .out_y     (y_w[i+1]),
         .out_z     (z_w[i+1]),
         .out_side  (side_w[i+1])
      );
   end

   assign quad  = side_w[STAGES][SIDE_W+1:SIDE_W];
   assign x_end = x_w[STAGES];
   assign y_end = y_w[STAGES];

   always_comb begin
      case (quad)
         QUAD_I: begin
            out_cos = x_end;
            out_sin = y_end;
         end
         QUAD_II: begin
            out_cos = -y_end;
            out_sin = x_end;
         end
         QUAD_III: begin
            out_cos = -x_end;
            out_sin = -y_end;
         end
         default: begin
            out_cos = y_end;
            out_sin = -x_end;
         end
      endcase
   end

   assign out_valid = valid_w[STAGES];
   assign out_side  = side_w[STAGES][SIDE_W-1:0];

endmodule

FILE: sv/ramped_frequency_phasor_source.sv
// ----------------------------------------------------------------------------
// ramped_frequency_phasor_source
// Phasor voltage source with raised-cosine frequency ramp and node currents.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_ready  sim_time
//   rsp      out        rsp_valid/rsp_ready  volt, inj1, inj2, region
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One word per cycle sustained while the skid word is empty. Each word passes
// through the two CORDIC cell rows (fade, then phasor) and the multiplier
// stages around them. Reset clears valids and all csr registers.
// Result register plus skid word; req_ready drops once the skid word is full,
// and the whole pipeline then holds. csr_ready is always high.
// ----------------------------------------------------------------------------
module ramped_frequency_phasor_source #(
   parameter int PHASE_BITS    = 32,
   parameter int CORDIC_STAGES = 18
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic        [31:0]                  req_sim_time,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [31:0]                  rsp_volt_re,
   output logic signed [31:0]                  rsp_volt_im,
   output logic signed [31:0]                  rsp_inj1_re,
   output logic signed [31:0]                  rsp_inj1_im,
   output logic                                rsp_inj1_valid,
   output logic signed [31:0]                  rsp_inj2_re,
   output logic signed [31:0]                  rsp_inj2_im,
   output logic                                rsp_inj2_valid,
   output logic        [1:0]                   rsp_region,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [rfps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [rfps_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rfps_pkg::*;

   localparam logic signed [CORDIC_XW:0] FADE_ONE = (CORDIC_XW + 1)'(ONE_Q30);

   // csr registers
   logic [31:0] amplitude_ff, phase_offset_ff, angular_rate_ff, switch_time_ff;
   logic [31:0] ramp_time_ff, ramp_rate_ff, conductance_ff;
   logic [1:0]  node_enables_ff;

   logic advance;

   // stage registers
   logic               s1_valid_ff;
   logic [31:0]        s1_time_ff;

   logic               s2_valid_ff;
   logic signed [63:0] s2_m_ff;
   logic [31:0]        s2_delta_ff;
   region_type         s2_region_ff;
   logic signed [64:0] s2_m_in;
   logic [32:0]        ramp_end;
   region_type         s2_region_in;

   logic               s3_valid_ff;
   logic [31:0]        s3_angle_ff;
   logic signed [63:0] s3_m_ff;
   region_type         s3_region_ff;
   logic [63:0]        ramp_prod;
   logic [31:0]        ramp_u;
   logic [31:0]        s3_angle_in;

   logic                        fade_valid;
   logic signed [CORDIC_XW-1:0] fade_cos, fade_sin;
   logic [65:0]                 fade_side;

   logic               s4_valid_ff;
   logic [30:0]        s4_fade_ff;
   logic [62:0]        s4_mag_ff;
   logic               s4_neg_ff;
   logic [35:0]        s4_m_ff;
   region_type         s4_region_ff;
   logic signed [CORDIC_XW:0] fade_sum, fade_half;
   logic [30:0]        s4_fade_in;
   logic signed [63:0] fade_m;

   logic               s5_valid_ff;
   logic [61:0]        s5_phi_ff;
   logic [62:0]        s5_plo_ff;
   logic               s5_neg_ff;
   logic [35:0]        s5_m_ff;
   region_type         s5_region_ff;

   logic               s6_valid_ff;
   logic [35:0]        s6_term_ff;
   region_type         s6_region_ff;
   logic [35:0]        ramp_scaled;
   logic [35:0]        s6_term_in;

   logic                    s7_valid_ff;
   logic [31:0]             s7_phase_ff;
   region_type              s7_region_ff;
   logic [PHASE_BITS+35:0]  term_wide;
   logic [PHASE_BITS+31:0]  offset_wide;
   logic [PHASE_BITS-1:0]   phase_sum;
   logic [PHASE_BITS+31:0]  phase_wide;

   logic                        rot_valid;
   logic signed [CORDIC_XW-1:0] rot_cos, rot_sin;
   logic [1:0]                  rot_side;

   logic               s8_valid_ff;
   logic signed [65:0] s8_re_ff, s8_im_ff;
   region_type         s8_region_ff;
   logic signed [CORDIC_XW-1:0] amp_s;

   logic               s9_valid_ff;
   logic signed [31:0] s9_vre_ff, s9_vim_ff;
   region_type         s9_region_ff;

   logic               s10_valid_ff;
   logic signed [65:0] s10_ire_ff, s10_iim_ff;
   logic signed [31:0] s10_vre_ff, s10_vim_ff;
   region_type         s10_region_ff;
   logic signed [32:0] cond_s;

   logic               s11_valid_ff;
   logic signed [31:0] s11_ire_ff, s11_iim_ff;
   logic signed [31:0] s11_vre_ff, s11_vim_ff;
   region_type         s11_region_ff;

   rsp_word_type up_word;
   rsp_word_type out_word_ff, skid_word_ff;
   logic         out_valid_ff, skid_valid_ff;

   // csr port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff    <= '0;
         phase_offset_ff <= '0;
         angular_rate_ff <= '0;
         switch_time_ff  <= '0;
         ramp_time_ff    <= '0;
         ramp_rate_ff    <= '0;
         conductance_ff  <= '0;
         node_enables_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_AMPLITUDE:    amplitude_ff    <= csr_data;
            REG_PHASE_OFFSET: phase_offset_ff <= csr_data;
            REG_ANGULAR_RATE: angular_rate_ff <= csr_data;
            REG_SWITCH_TIME:  switch_time_ff  <= csr_data;
            REG_RAMP_TIME:    ramp_time_ff    <= csr_data;
            REG_RAMP_RATE:    ramp_rate_ff    <= csr_data;
            REG_CONDUCTANCE:  conductance_ff  <= csr_data;
            REG_NODE_ENABLES: node_enables_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   assign advance   = !skid_valid_ff;
   assign req_ready = advance;

   // region, omega*t, t - switch_time
   always_comb begin
      s2_m_in  = $signed(angular_rate_ff) * $signed({1'b0, s1_time_ff});
      ramp_end = {1'b0, switch_time_ff} + {1'b0, ramp_time_ff};
      if (s1_time_ff < switch_time_ff) begin
         s2_region_in = REGION_BEFORE;
      end else if ({1'b0, s1_time_ff} < ramp_end) begin
         s2_region_in = REGION_RAMP;
      end else begin
         s2_region_in = REGION_AFTER;
      end
   end

   // fade angle = u/2 - quarter turn
   always_comb begin
      ramp_prod   = 64'(s2_delta_ff) * 64'(ramp_rate_ff);
      ramp_u      = (|ramp_prod[63:36]) ? '1 : ramp_prod[35:4];
      s3_angle_in = {1'b0, ramp_u[31:1]} - QUARTER_TURN;
   end

   rfps_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (66)
   ) u_fade_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s3_valid_ff),
      .in_phase  (s3_angle_ff),
      .in_side   ({s3_m_ff, s3_region_ff}),
      .out_valid (fade_valid),
      .out_cos   (fade_cos),
      .out_sin   (fade_sin),
      .out_side  (fade_side)
   );

   // fade = clamp((1 + sin)/2), |m|
   always_comb begin
      fade_m    = $signed(fade_side[65:2]);
      fade_sum  = (CORDIC_XW + 1)'(fade_sin) + FADE_ONE;
      fade_half = fade_sum >>> 1;
      if (fade_half < 0) begin
         s4_fade_in = '0;
      end else if (fade_half > FADE_ONE) begin
         s4_fade_in = ONE_Q30;
      end else begin
         s4_fade_in = fade_half[30:0];
      end
   end

   // ramp term and region select, low 36 bits only
   always_comb begin
      ramp_scaled = {s5_phi_ff[33:0], 2'b00} + 36'(s5_plo_ff[62:30]);
      case (s5_region_ff)
         REGION_RAMP:  s6_term_in = s5_neg_ff ? -ramp_scaled : ramp_scaled;
         REGION_AFTER: s6_term_in = s5_m_ff;
         default:      s6_term_in = '0;
      endcase
   end

   // phase accumulate in PHASE_BITS, then to 32-bit turns
   always_comb begin
      term_wide   = {s6_term_ff, {PHASE_BITS{1'b0}}};
      offset_wide = {phase_offset_ff, {PHASE_BITS{1'b0}}};
      phase_sum   = term_wide[PHASE_BITS+35:36] + offset_wide[PHASE_BITS+31:32];
      phase_wide  = {phase_sum, 32'b0};
   end

   rfps_cordic #(
      .STAGES (CORDIC_STAGES),
      .SIDE_W (2)
   ) u_phasor_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s7_valid_ff),
      .in_phase  (s7_phase_ff),
      .in_side   (s7_region_ff),
      .out_valid (rot_valid),
      .out_cos   (rot_cos),
      .out_sin   (rot_sin),
      .out_side  (rot_side)
   );

   assign amp_s  = $signed({1'b0, amplitude_ff});
   assign cond_s = $signed({1'b0, conductance_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         s11_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= fade_valid;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= rot_valid;
         s9_valid_ff  <= s8_valid_ff;
         s10_valid_ff <= s9_valid_ff;
         s11_valid_ff <= s10_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_time_ff    <= req_sim_time;

         s2_m_ff       <= s2_m_in[63:0];
         s2_delta_ff   <= s1_time_ff - switch_time_ff;
         s2_region_ff  <= s2_region_in;

         s3_angle_ff   <= s3_angle_in;
         s3_m_ff       <= s2_m_ff;
         s3_region_ff  <= s2_region_ff;

         s4_fade_ff    <= s4_fade_in;
         s4_mag_ff     <= fade_m[63] ? 63'(-fade_m) : 63'(fade_m);
         s4_neg_ff     <= fade_m[63];
         s4_m_ff       <= fade_side[37:2];
         s4_region_ff  <= region_type'(fade_side[1:0]);

         s5_phi_ff     <= 62'(s4_mag_ff[62:32]) * 62'(s4_fade_ff);
         s5_plo_ff     <= 63'(s4_mag_ff[31:0]) * 63'(s4_fade_ff);
         s5_neg_ff     <= s4_neg_ff;
         s5_m_ff       <= s4_m_ff;
         s5_region_ff  <= s4_region_ff;

         s6_term_ff    <= s6_term_in;
         s6_region_ff  <= s5_region_ff;

         s7_phase_ff   <= phase_wide[PHASE_BITS+31:PHASE_BITS];
         s7_region_ff  <= s6_region_ff;

         s8_re_ff      <= amp_s * rot_cos;
         s8_im_ff      <= amp_s * rot_sin;
         s8_region_ff  <= region_type'(rot_side);

         s9_vre_ff     <= sat32(s8_re_ff >>> 30);
         s9_vim_ff     <= sat32(s8_im_ff >>> 30);
         s9_region_ff  <= s8_region_ff;

         s10_ire_ff    <= s9_vre_ff * cond_s;
         s10_iim_ff    <= s9_vim_ff * cond_s;
         s10_vre_ff    <= s9_vre_ff;
         s10_vim_ff    <= s9_vim_ff;
         s10_region_ff <= s9_region_ff;

         s11_ire_ff    <= sat32(s10_ire_ff >>> 16);
         s11_iim_ff    <= sat32(s10_iim_ff >>> 16);
         s11_vre_ff    <= s10_vre_ff;
         s11_vim_ff    <= s10_vim_ff;
         s11_region_ff <= s10_region_ff;
      end
   end

   // result word, grounded nodes read zero
   always_comb begin
      up_word.volt_re    = s11_vre_ff;
      up_word.volt_im    = s11_vim_ff;
      up_word.inj1_valid = node_enables_ff[0];
      up_word.inj1_re    = node_enables_ff[0] ? s11_ire_ff : '0;
      up_word.inj1_im    = node_enables_ff[0] ? s11_iim_ff : '0;
      up_word.inj2_valid = node_enables_ff[1];
      up_word.inj2_re    = node_enables_ff[1] ? neg_sat32(s11_ire_ff) : '0;
      up_word.inj2_im    = node_enables_ff[1] ? neg_sat32(s11_iim_ff) : '0;
      up_word.region     = s11_region_ff;
   end

   // result register and skid word
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         out_valid_ff  <= skid_valid_ff || s11_valid_ff;
         skid_valid_ff <= 1'b0;
      end else if (s11_valid_ff && !skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         out_word_ff <= skid_valid_ff ? skid_word_ff : up_word;
      end else if (!skid_valid_ff) begin
         skid_word_ff <= up_word;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_volt_re    = out_word_ff.volt_re;
   assign rsp_volt_im    = out_word_ff.volt_im;
   assign rsp_inj1_re    = out_word_ff.inj1_re;
   assign rsp_inj1_im    = out_word_ff.inj1_im;
   assign rsp_inj1_valid = out_word_ff.inj1_valid;
   assign rsp_inj2_re    = out_word_ff.inj2_re;
   assign rsp_inj2_im    = out_word_ff.inj2_im;
   assign rsp_inj2_valid = out_word_ff.inj2_valid;
   assign rsp_region     = out_word_ff.region;

endmodule

FILE: sv/rfps_checker.sv
// ----------------------------------------------------------------------------
// rfps_checker
// Port-level checks of the phasor source, bound to the top level.
// ----------------------------------------------------------------------------
`include "ramped_frequency_phasor_source_macros.svh"

module rfps_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_volt_re,
   input logic signed [31:0] rsp_inj1_re,
   input logic signed [31:0] rsp_inj1_im,
   input logic               rsp_inj1_valid,
   input logic signed [31:0] rsp_inj2_re,
   input logic               rsp_inj2_valid
);
   logic both_nodes;
   logic inj1_min;
   logic inj2_ok;

   assign both_nodes = rsp_valid && rsp_inj1_valid && rsp_inj2_valid;
   assign inj1_min   = rsp_inj1_re == 32'sh8000_0000;
   assign inj2_ok    = inj1_min ? (rsp_inj2_re == 32'sh7fff_ffff)
                                : (rsp_inj2_re == -rsp_inj1_re);

   `RFPS_ASSERT_STALL(a_volt_hold, rsp_volt_re, "volt changed while stalled")
   `RFPS_ASSERT(a_ground, rsp_valid && !rsp_inj1_valid |-> rsp_inj1_re == 0 && rsp_inj1_im == 0, "grounded node 1 not zero")
   `RFPS_ASSERT(a_inj2_neg, both_nodes |-> inj2_ok, "node 2 not negated node 1")
   `RFPS_ASSERT(a_backpressure, !req_ready |-> rsp_valid, "req stalled with no word out")

endmodule

bind ramped_frequency_phasor_source rfps_checker u_rfps_checker (.*);
